[src/rau_pkg.sv]
// Shared types, codes and constants of the rational arithmetic unit.
package rau_pkg;

   localparam int WIDTH = 32;
   localparam int RES_W = (WIDTH < 2) ? 2 : ((WIDTH > 32) ? 32 : WIDTH);
   localparam logic [63:0] RES_LIM = 64'(1) << (RES_W - 1);
   localparam int DIV_W = 64;
   localparam int MUL_W = 32;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   localparam logic [1:0] REL_LESS    = 2'd0;
   localparam logic [1:0] REL_EQUAL   = 2'd1;
   localparam logic [1:0] REL_GREATER = 2'd2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_ZERO = 2'd1;
   localparam logic [1:0] STAT_OVF  = 2'd2;

   typedef enum logic [2:0] {
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_CMP
   } kind_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic [1:0]         relation;
      logic [1:0]         status;
   } rsp_word_type;

endpackage

[src/rau_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module rau_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rau_pkg::DIV_W-1:0] dividend,
   input  logic [rau_pkg::DIV_W-1:0] divisor,
   output logic                      busy,
   output logic                      done,
   output logic [rau_pkg::DIV_W-1:0] quotient,
   output logic [rau_pkg::DIV_W-1:0] remainder
);
   import rau_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [$clog2(DIV_W)-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]         q_ff, q_in;
   logic [DIV_W-1:0]         r_ff, r_in;
   logic [DIV_W-1:0]         d_ff, d_in;
   logic [DIV_W:0]           trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      trial   = {r_ff, q_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = DIV_W'(trial - {1'b0, d_ff});
            q_in = {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            r_in = trial[DIV_W-1:0];
            q_in = {q_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

[src/rau_mul.sv]
// Registered 32 by 32 unsigned multiplier.
module rau_mul (
   input  logic                        clock,
   input  logic [rau_pkg::MUL_W-1:0]   op_a,
   input  logic [rau_pkg::MUL_W-1:0]   op_b,
   output logic [2*rau_pkg::MUL_W-1:0] product
);
   import rau_pkg::*;

   logic [2*MUL_W-1:0] product_ff, product_in;

   assign product_in = {{MUL_W{1'b0}}, op_a} * {{MUL_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

[src/rational_arithmetic_unit.sv]
// Top level: sequencer of the rational arithmetic unit.
// Usage:
//   req channel carries one word: an operation code and two fractions
//   a_num/a_den and b_num/b_den. rsp channel returns one word per request:
//   reduced numerator, positive denominator, compare relation and status.
//   req_ready is high only while the sequencer is idle; a request is then
//   worked on alone until its result is loaded into the output register.
// Sequence: a zero denominator or divide by zero goes straight to the
//   result; compare runs the two cross products only. Each Euclid step
//   and each reduction quotient is one pass through the shared divider.
//   Multiply and divide run one gcd pass; add and subtract run two.
// Throughput: one word at a time; req_ready returns in the same cycle that
//   the result appears in the output register.
// Reset: synchronous, active high; returns to idle with no result pending.
// Stall: a finished result waits in the output register while rsp_ready is
//   low; a new request may be taken meanwhile, and its result is held back
//   until the register is free.
module rational_arithmetic_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rau_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rau_pkg::rsp_word_type rsp_word
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GCD_TEST,
      ST_GCD_WAIT,
      ST_QUO_START,
      ST_QUO_WAIT,
      ST_MUL_ISSUE,
      ST_MUL_TAKE,
      ST_SUM,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   kind_type     kind_ff, kind_in;
   logic         aneg_ff, aneg_in, bneg_ff, bneg_in;
   logic [31:0]  amag_ff, amag_in, bmag_ff, bmag_in;
   logic [31:0]  da_ff, da_in, db_ff, db_in;
   logic [31:0]  qa_ff, qa_in, qb_ff, qb_in;
   logic [63:0]  x_ff, x_in, y_ff, y_in;
   logic [63:0]  aprod_ff, aprod_in, bprod_ff, bprod_in;
   logic [63:0]  den_ff, den_in, nmag_ff, nmag_in;
   logic         nneg_ff, nneg_in;
   logic         phase_ff, phase_in;
   logic [1:0]   dsel_ff, dsel_in;
   logic [1:0]   mi_ff, mi_in;
   logic [1:0]   status_ff, status_in;
   logic [1:0]   rel_ff, rel_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic         div_start, div_busy, div_done;
   logic [63:0]  div_dividend, div_divisor, div_quo, div_rem;
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_p;

   logic         an_neg, ad_neg, bn_neg, bd_neg;
   logic [31:0]  an_mag, ad_mag, bn_mag, bd_mag;
   logic         req_err;
   logic         s_neg, b_eff_neg;
   logic [63:0]  s_mag;
   logic         ovf;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   rau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   rau_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   assign an_neg  = req_word.a_num[31];
   assign ad_neg  = req_word.a_den[31];
   assign bn_neg  = req_word.b_num[31];
   assign bd_neg  = req_word.b_den[31];
   assign an_mag  = mag32(req_word.a_num);
   assign ad_mag  = mag32(req_word.a_den);
   assign bn_mag  = mag32(req_word.b_num);
   assign bd_mag  = mag32(req_word.b_den);
   assign req_err = (ad_mag == '0) || (bd_mag == '0) ||
                    ((req_word.operation == OP_DIV) && (bn_mag == '0));

   assign div_start = ((state_ff == ST_GCD_TEST) && (y_ff != '0)) ||
                      (state_ff == ST_QUO_START);

   always_comb begin
      if (state_ff == ST_GCD_TEST) begin
         div_dividend = x_ff;
         div_divisor  = y_ff;
      end else begin
         div_divisor = x_ff;
         unique case (dsel_ff)
            2'd0:    div_dividend = {32'd0, da_ff};
            2'd1:    div_dividend = {32'd0, db_ff};
            2'd2:    div_dividend = nmag_ff;
            default: div_dividend = den_ff;
         endcase
      end
   end

   always_comb begin
      mul_a = amag_ff;
      mul_b = db_ff;
      unique case (mi_ff)
         2'd0: begin
            priority case (kind_ff)
               KIND_ADD, KIND_SUB: begin mul_a = qa_ff;   mul_b = db_ff;   end
               KIND_MUL:           begin mul_a = amag_ff; mul_b = bmag_ff; end
               default:            begin mul_a = amag_ff; mul_b = db_ff;   end
            endcase
         end
         2'd1: begin
            priority case (kind_ff)
               KIND_ADD, KIND_SUB: begin mul_a = amag_ff; mul_b = qb_ff;   end
               KIND_MUL:           begin mul_a = da_ff;   mul_b = db_ff;   end
               KIND_DIV:           begin mul_a = da_ff;   mul_b = bmag_ff; end
               default:            begin mul_a = bmag_ff; mul_b = da_ff;   end
            endcase
         end
         default: begin
            mul_a = bmag_ff;
            mul_b = qa_ff;
         end
      endcase
   end

   // signed sum of a and the (possibly negated) b product
   always_comb begin
      b_eff_neg = bneg_ff;
      if ((kind_ff == KIND_CMP) && (bprod_ff != '0)) begin
         b_eff_neg = ~bneg_ff;
      end
      if (aneg_ff == b_eff_neg) begin
         s_neg = aneg_ff;
         s_mag = aprod_ff + bprod_ff;
      end else if (aprod_ff >= bprod_ff) begin
         s_neg = aneg_ff;
         s_mag = aprod_ff - bprod_ff;
      end else begin
         s_neg = b_eff_neg;
         s_mag = bprod_ff - aprod_ff;
      end
      if (s_mag == '0) begin
         s_neg = 1'b0;
      end
   end

   assign ovf = (nneg_ff ? (nmag_ff > RES_LIM) : (nmag_ff >= RES_LIM)) ||
                (den_ff >= RES_LIM);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      aneg_in      = aneg_ff;
      bneg_in      = bneg_ff;
      amag_in      = amag_ff;
      bmag_in      = bmag_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      aprod_in     = aprod_ff;
      bprod_in     = bprod_ff;
      den_in       = den_ff;
      nmag_in      = nmag_ff;
      nneg_in      = nneg_ff;
      phase_in     = phase_ff;
      dsel_in      = dsel_ff;
      mi_in        = mi_ff;
      status_in    = status_ff;
      rel_in       = rel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               aneg_in   = (an_neg != ad_neg) && (an_mag != '0);
               bneg_in   = (bn_neg != bd_neg) && (bn_mag != '0);
               amag_in   = an_mag;
               bmag_in   = bn_mag;
               da_in     = ad_mag;
               db_in     = bd_mag;
               status_in = STAT_OK;
               rel_in    = REL_LESS;
               mi_in     = 2'd0;
               phase_in  = 1'b0;
               priority case (req_word.operation)
                  OP_ADD:  kind_in = KIND_ADD;
                  OP_SUB:  kind_in = KIND_SUB;
                  OP_MUL:  kind_in = KIND_MUL;
                  OP_DIV:  kind_in = KIND_DIV;
                  default: kind_in = KIND_CMP;
               endcase
               if ((req_word.operation == OP_SUB) && (bn_mag != '0)) begin
                  bneg_in = ~((bn_neg != bd_neg) && (bn_mag != '0));
               end
               if (req_err) begin
                  status_in = STAT_ZERO;
                  state_in  = ST_DONE;
               end else if ((req_word.operation == OP_ADD) ||
                            (req_word.operation == OP_SUB)) begin
                  x_in     = {32'd0, ad_mag};
                  y_in     = {32'd0, bd_mag};
                  state_in = ST_GCD_TEST;
               end else begin
                  state_in = ST_MUL_ISSUE;
               end
            end
         end
         ST_GCD_TEST: begin
            if (y_ff == '0) begin
               dsel_in  = phase_ff ? 2'd2 : 2'd0;
               state_in = ST_QUO_START;
            end else begin
               state_in = ST_GCD_WAIT;
            end
         end
         ST_GCD_WAIT: begin
            if (div_done) begin
               x_in     = y_ff;
               y_in     = div_rem;
               state_in = ST_GCD_TEST;
            end
         end
         ST_QUO_START: begin
            state_in = ST_QUO_WAIT;
         end
         ST_QUO_WAIT: begin
            if (div_done) begin
               unique case (dsel_ff)
                  2'd0: begin
                     qa_in    = div_quo[31:0];
                     dsel_in  = 2'd1;
                     state_in = ST_QUO_START;
                  end
                  2'd1: begin
                     qb_in    = div_quo[31:0];
                     mi_in    = 2'd0;
                     state_in = ST_MUL_ISSUE;
                  end
                  2'd2: begin
                     nmag_in  = div_quo;
                     dsel_in  = 2'd3;
                     state_in = ST_QUO_START;
                  end
                  default: begin
                     den_in   = div_quo;
                     state_in = ST_CHECK;
                  end
               endcase
            end
         end
         ST_MUL_ISSUE: begin
            state_in = ST_MUL_TAKE;
         end
         ST_MUL_TAKE: begin
            priority case (kind_ff)
               KIND_ADD, KIND_SUB: begin
                  unique case (mi_ff)
                     2'd0:    den_in   = mul_p;
                     2'd1:    aprod_in = mul_p;
                     default: bprod_in = mul_p;
                  endcase
               end
               KIND_CMP: begin
                  if (mi_ff == 2'd0) begin
                     aprod_in = mul_p;
                  end else begin
                     bprod_in = mul_p;
                  end
               end
               default: begin
                  if (mi_ff == 2'd0) begin
                     aprod_in = mul_p;
                  end else begin
                     den_in = mul_p;
                  end
               end
            endcase
            if (mi_ff == (((kind_ff == KIND_ADD) || (kind_ff == KIND_SUB)) ? 2'd2 : 2'd1))
            begin
               state_in = ST_SUM;
            end else begin
               mi_in    = mi_ff + 2'd1;
               state_in = ST_MUL_ISSUE;
            end
         end
         ST_SUM: begin
            if (kind_ff == KIND_CMP) begin
               rel_in   = (s_mag == '0) ? REL_EQUAL : (s_neg ? REL_LESS : REL_GREATER);
               state_in = ST_DONE;
            end else begin
               if ((kind_ff == KIND_MUL) || (kind_ff == KIND_DIV)) begin
                  nmag_in = aprod_ff;
                  nneg_in = (aneg_ff != bneg_ff) && (aprod_ff != '0);
               end else begin
                  nmag_in = s_mag;
                  nneg_in = s_neg;
               end
               x_in     = nmag_in;
               y_in     = den_ff;
               phase_in = 1'b1;
               state_in = ST_GCD_TEST;
            end
         end
         ST_CHECK: begin
            if (ovf) begin
               status_in = STAT_OVF;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_word_in.res_num  = '0;
               rsp_word_in.res_den  = 31'd1;
               rsp_word_in.relation = REL_LESS;
               rsp_word_in.status   = status_ff;
               if (status_ff == STAT_OK) begin
                  if (kind_ff == KIND_CMP) begin
                     rsp_word_in.relation = rel_ff;
                  end else begin
                     rsp_word_in.res_num = nneg_ff ? (~nmag_ff[31:0] + 32'd1)
                                                   : nmag_ff[31:0];
                     rsp_word_in.res_den = den_ff[30:0];
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      aneg_ff     <= aneg_in;
      bneg_ff     <= bneg_in;
      amag_ff     <= amag_in;
      bmag_ff     <= bmag_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      qa_ff       <= qa_in;
      qb_ff       <= qb_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      aprod_ff    <= aprod_in;
      bprod_ff    <= bprod_in;
      den_ff      <= den_in;
      nmag_ff     <= nmag_in;
      nneg_ff     <= nneg_in;
      phase_ff    <= phase_in;
      dsel_ff     <= dsel_in;
      mi_ff       <= mi_in;
      status_ff   <= status_in;
      rel_ff      <= rel_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer took a second word while busy");

   a_ok_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == STAT_OK) |-> (rsp_word.res_den != '0))
      else $error("reduced denominator is zero");

   a_relation_only_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.relation != REL_LESS) |->
         (rsp_word.res_num == '0) && (rsp_word.res_den == 31'd1))
      else $error("relation set on arithmetic result");

   a_div_wait_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD_WAIT) || (state_ff == ST_QUO_WAIT) |-> div_busy || div_done)
      else $error("waiting on idle divider");

endmodule

[bench/tb_rational_arithmetic_unit.sv]
// Testbench of the rational arithmetic unit: random and directed fractions, scoreboard check.
module tb_rational_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   class rational_scoreboard;
      rsp_word_type pending_results[$];
      int unsigned  fail_count;

      function new();
         fail_count = 0;
      endfunction

      static function logic [63:0] field_mag(logic [31:0] v);
         return {32'd0, v[31] ? (~v + 32'd1) : v};
      endfunction

      static function logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
         logic [63:0] t;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         return x;
      endfunction

      // signed sum of sign-magnitude values; bit 64 holds the sign
      static function logic [64:0] signed_sum(bit xn, logic [63:0] xm, bit yn, logic [63:0] ym);
         bit          rn;
         logic [63:0] rm;
         if (xn == yn) begin
            rn = xn;
            rm = xm + ym;
         end else if (xm >= ym) begin
            rn = xn;
            rm = xm - ym;
         end else begin
            rn = yn;
            rm = ym - xm;
         end
         if (rm == 0) rn = 0;
         return {rn, rm};
      endfunction

      static function rsp_word_type compute_fraction(req_word_type w);
         logic [63:0]  an, ad, bn, bd, am, bm, den, g, nm;
         logic [64:0]  s;
         bit           aneg, bneg, nneg;
         logic [2:0]   op;
         rsp_word_type r;
         op = w.operation;
         an = field_mag(w.a_num);
         ad = field_mag(w.a_den);
         bn = field_mag(w.b_num);
         bd = field_mag(w.b_den);
         r = '{res_num: 0, res_den: 31'd1, relation: REL_LESS, status: STAT_OK};
         nneg = 0;
         nm = 0;
         den = 1;
         if (ad == 0 || bd == 0 || (op == OP_DIV && bn == 0)) begin
            r.status = STAT_ZERO;
            return r;
         end
         aneg = (w.a_num[31] != w.a_den[31]) && an != 0;
         bneg = (w.b_num[31] != w.b_den[31]) && bn != 0;
         am = an;
         bm = bn;
         if (op == OP_ADD || op == OP_SUB) begin
            if (op == OP_SUB && bm != 0) bneg = !bneg;
            g = euclid_gcd(ad, bd);
            den = (ad / g) * bd;
            am = am * (bd / g);
            bm = bm * (ad / g);
            s = signed_sum(aneg, am, bneg, bm);
            nneg = s[64];
            nm = s[63:0];
         end else if (op == OP_MUL) begin
            nneg = aneg != bneg;
            nm = am * bm;
            den = ad * bd;
         end else if (op == OP_DIV) begin
            nneg = aneg != bneg;
            nm = am * bd;
            den = ad * bm;
         end else begin
            am = am * bd;
            bm = bm * ad;
            if (bm != 0) bneg = !bneg;
            s = signed_sum(aneg, am, bneg, bm);
            r.relation = (s[63:0] == 0) ? REL_EQUAL : (s[64] ? REL_LESS : REL_GREATER);
            return r;
         end
         if (nm == 0) nneg = 0;
         g = euclid_gcd(nm, den);
         if (g == 0) g = 1;
         nm = nm / g;
         den = den / g;
         if ((nneg ? (nm > RES_LIM) : (nm >= RES_LIM)) || den >= RES_LIM) begin
            r.status = STAT_OVF;
         end else begin
            r.res_num = nneg ? -nm[31:0] : nm[31:0];
            r.res_den = den[30:0];
         end
         return r;
      endfunction

      function void note_request(req_word_type w);
         pending_results.push_back(compute_fraction(w));
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type exp;
         if (pending_results.size() == 0) begin
            $error("unexpected result word %h", got);
            fail_count++;
            return;
         end
         exp = pending_results.pop_front();
         if (got.res_num !== exp.res_num) begin
            $error("res_num expected %0d actual %0d", exp.res_num, got.res_num);
            fail_count++;
         end
         if (got.res_den !== exp.res_den) begin
            $error("res_den expected %0d actual %0d", exp.res_den, got.res_den);
            fail_count++;
         end
         if (got.relation !== exp.relation) begin
            $error("relation expected %0d actual %0d", exp.relation, got.relation);
            fail_count++;
         end
         if (got.status !== exp.status) begin
            $error("status expected %0d actual %0d", exp.status, got.status);
            fail_count++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 0;
   rsp_word_type rsp_word;

   rational_scoreboard scoreboard = new();
   int unsigned        results_seen = 0;
   bit                 quiet_phase = 0;

   rational_arithmetic_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   function automatic int unsigned gap_length();
      if (quiet_phase) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(20, 150);
   endfunction

   task automatic idle_sender(int unsigned n);
      if (n == 0) return;
      @(negedge clock);
      req_valid <= 0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_word(req_word_type w);
      @(negedge clock);
      req_valid <= 1;
      req_word  <= w;
      do @(posedge clock); while (!(req_valid && req_ready));
      scoreboard.note_request(w);
   endtask

   task automatic send_ops(logic [31:0] an, logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
      req_word_type w;
      w = '{operation: OP_ADD, a_num: an, a_den: ad, b_num: bn, b_den: bd};
      send_word(w);
      w.operation = OP_SUB;
      send_word(w);
      w.operation = OP_MUL;
      send_word(w);
      w.operation = OP_DIV;
      send_word(w);
      w.operation = OP_CMP;
      send_word(w);
   endtask

   function automatic logic [31:0] random_value();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 12) return 32'($signed($urandom_range(0, 2000)) - 1000);
      if (pick < 14) return $urandom();
      if (pick < 15) return 32'h8000_0000;
      if (pick < 16) return 32'h7fff_ffff;
      if (pick < 17) return 32'hffff_ffff;
      if (pick < 18) return 32'(1 << $urandom_range(0, 31));
      return 32'($urandom_range(0, 65535));
   endfunction

   function automatic logic [31:0] random_denominator();
      logic [31:0] v;
      v = random_value();
      if (v == 0 && $urandom_range(0, 3) != 0) v = 1;
      return v;
   endfunction

   initial begin
      req_word_type w;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_ops(32'd1, 32'd2, 32'd1, 32'd3);
      send_ops(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      send_ops(32'h8000_0000, 32'hffff_ffff, 32'd3, 32'h8000_0000);
      send_ops(32'd0, 32'hffff_fffb, 32'd0, 32'd7);
      send_ops(32'd5, 32'd0, 32'd1, 32'd2);
      w = '{operation: OP_DIV, a_num: 3, a_den: 4, b_num: 0, b_den: -9};
      send_word(w);
      w = '{operation: 3'd7, a_num: -6, a_den: 4, b_num: 3, b_den: -2};
      send_word(w);
      for (int i = 0; i < 1920; i++) begin
         if (i % 200 == 0) quiet_phase = $urandom_range(0, 2) == 0;
         w.operation = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
         w.a_num = random_value();
         w.a_den = random_denominator();
         w.b_num = random_value();
         w.b_den = random_denominator();
         send_word(w);
         idle_sender(gap_length());
      end
      idle_sender(1);
      while (scoreboard.pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (scoreboard.fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      int unsigned hold;
      bit          long_hold_done;
      hold = 0;
      long_hold_done = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            scoreboard.check_result(rsp_word);
            results_seen++;
         end
         @(negedge clock);
         if (!long_hold_done && results_seen == 150) begin
            long_hold_done = 1;
            hold = 5000;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 0;
         end else if (quiet_phase) begin
            rsp_ready <= 1;
         end else if ($urandom_range(0, 49) == 0) begin
            hold = $urandom_range(20, 300);
            rsp_ready <= 0;
         end else begin
            rsp_ready <= $urandom_range(0, 3) != 0;
         end
      end
   end

   initial begin
      #1_000_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
